// ===== rtl/lpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg: shared types and constants for the linked peak limiter
// Sequencer states, divider status and register indexes.
// ----------------------------------------------------------------------------
package lpl_pkg;

  // Ceiling floor (about -6 dB) and default release coefficient, Q16 scale.
  localparam int unsigned CEIL_MIN_Q16  = 32845;
  localparam int unsigned COEF_RESET_Q16 = 65519;

  localparam int CFG_ADDR_BITS = 2;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CEILING_GAIN  = 2'd0,
    REG_RELEASE_COEFF = 2'd1
  } lpl_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_DIV,
    ST_REL,
    ST_UPD,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } lpl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lpl_div_stat_t;

endpackage

// ===== rtl/linked_peak_limiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_peak_limiter_top: stereo peak limiter, instant attack, exp. release
// Shared-gain limiter: linked peak, ceiling/peak division, one-pole release,
// gain applied to both channels through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stereo frame per beat; tdata = {right, left}, tlast marks the
//           last frame of a processing block.
//   out_* : one limited frame per input beat, same order; tlast echoes the
//           input tlast. block_reduced is valid on the tlast beat only.
//   cfg_* : register writes (0 = ceiling gain Q1.G, 1 = release coeff Q0.G),
//           taken on any clock with cfg_we high; write only while idle.
// Timing:
//   A frame is taken only when the sequencer is idle. A frame that needs
//   no reduction steps through peak, release, update, left multiply, right
//   multiply and done to the output register; one above the ceiling adds the
//   bit-serial divide step. The next frame is taken once back in idle.
// Reset (rst_n low, synchronous): gain back to unity, block flag cleared,
//   registers back to defaults, output channel empty.
// Stall: the finished frame sits in the output register until out_tready;
//   the sequencer holds in its final step while that register is full.
// ----------------------------------------------------------------------------
module linked_peak_limiter_top import lpl_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + GAIN_FRAC_BITS + 3 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_tvalid,
  output logic                      in_tready,
  // sample_left, sample_right, zero pad
  input  logic [IN_W-1:0]           in_tdata,
  input  logic                      in_tlast,   // end_of_block

  output logic                      out_tvalid,
  input  logic                      out_tready,
  // limited_left, limited_right, applied_gain, reducing, block_reduced, pad
  output logic [OUT_W-1:0]          out_tdata,
  output logic                      out_tlast,  // last_of_block

  input  logic                      cfg_we,
  input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [GAIN_FRAC_BITS:0]   cfg_wdata
);

  localparam int S  = SAMPLE_BITS;
  localparam int G  = GAIN_FRAC_BITS;
  localparam int MA = (S > G + 1) ? S : G + 1;   // multiplier A width
  localparam int PW = MA + G + 2;                 // product width

  localparam longint unsigned CeilMinL =
    ((64'(CEIL_MIN_Q16) << GAIN_FRAC_BITS) + 64'd32768) >> 16;
  localparam longint unsigned CoefRstL =
    ((64'(COEF_RESET_Q16) << GAIN_FRAC_BITS) + 64'd32768) >> 16;

  localparam logic [G:0]   UNITY      = (G+1)'(1) << G;
  localparam logic [G:0]   CEIL_MIN   = (G+1)'(CeilMinL);
  localparam logic [G-1:0] COEF_RESET = G'(CoefRstL);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  lpl_state_t state_r, state_nxt;

  logic [G:0]   ceil_r;
  logic [G-1:0] coef_r;
  logic [G:0]   held_r;
  logic         any_red_r;

  logic [S-1:0] sl_r, sr_r;
  logic         eob_r;
  logic [G:0]   req_r;
  logic signed [PW-1:0] prod_r;
  logic [S-1:0] lim_l_r;

  logic         out_valid_r;
  logic [S-1:0] out_left_r, out_right_r;
  logic [G:0]   out_gain_r;
  logic         out_red_r, out_blk_r, out_last_r;

  // --------------------------------------------------------------------------
  // peak, ceiling clamp, over-ceiling test
  // --------------------------------------------------------------------------
  logic [S-1:0]   mag_l, mag_r, peak;
  logic [G:0]     ceil_c;
  logic [S+G-1:0] num;
  logic           exceed;

  always_comb begin
    mag_l  = sl_r[S-1] ? (~sl_r + 1'b1) : sl_r;   // most negative -> 2^(S-1)
    mag_r  = sr_r[S-1] ? (~sr_r + 1'b1) : sr_r;
    peak   = (mag_l > mag_r) ? mag_l : mag_r;
    if (ceil_r < CEIL_MIN) begin
      ceil_c = CEIL_MIN;
    end else if (ceil_r > UNITY) begin
      ceil_c = UNITY;
    end else begin
      ceil_c = ceil_r;
    end
    num    = {ceil_c, {(S-1){1'b0}}};
    exceed = ({peak, {G{1'b0}}} > num);
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  logic          div_start;
  logic [G-1:0]  div_q;
  lpl_div_stat_t div_stat;

  lpl_div #(
    .SAMPLE_BITS   (S),
    .GAIN_FRAC_BITS(G)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend_hi(num[S+G-1:G]),
    .dividend_lo(num[G-1:0]),
    .divisor    (peak),
    .quotient   (div_q),
    .stat       (div_stat)
  );

  // --------------------------------------------------------------------------
  // shared multiplier: release term, then left, then right
  // --------------------------------------------------------------------------
  logic signed [MA-1:0] mul_a;
  logic signed [G+1:0]  mul_b;
  logic [G:0]           drop;

  always_comb begin
    drop = UNITY - held_r;
    unique case (state_r)
      ST_MUL_L: begin
        mul_a = MA'($signed(sl_r));
        mul_b = (G+2)'(held_r);
      end
      ST_MUL_R: begin
        mul_a = MA'($signed(sr_r));
        mul_b = (G+2)'(held_r);
      end
      default: begin
        mul_a = MA'(coef_r);
        mul_b = (G+2)'(drop);
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // gain update
  // --------------------------------------------------------------------------
  logic [G:0] rel, gain_nxt;

  always_comb begin
    rel = UNITY - (G+1)'(prod_r[2*G-1:G]);
    if (req_r < held_r) begin
      gain_nxt = req_r;                       // instant attack
    end else begin
      gain_nxt = (rel < req_r) ? rel : req_r; // release, capped
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_PEAK;
      ST_PEAK: begin
        if (exceed) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_REL;
        end
      end
      ST_DIV:   if (div_stat.done) state_nxt = ST_REL;
      ST_REL:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_MUL_L;
      ST_MUL_L: state_nxt = ST_MUL_R;
      ST_MUL_R: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state: config registers, held gain, block flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r      <= UNITY;
      coef_r      <= COEF_RESET;
      held_r      <= UNITY;
      any_red_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CEILING_GAIN:  ceil_r <= cfg_wdata;
          REG_RELEASE_COEFF: coef_r <= cfg_wdata[G-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_UPD) begin
        held_r    <= gain_nxt;
        any_red_r <= any_red_r | (gain_nxt < UNITY);
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        if (eob_r) begin
          any_red_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sl_r  <= in_tdata[S-1:0];
      sr_r  <= in_tdata[2*S-1:S];
      eob_r <= in_tlast;
    end
    if (state_r == ST_PEAK && !exceed) begin
      req_r <= UNITY;
    end
    if (state_r == ST_DIV && div_stat.done) begin
      req_r <= {1'b0, div_q};
    end
    if (state_r == ST_REL || state_r == ST_MUL_L || state_r == ST_MUL_R) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ST_MUL_R) begin
      lim_l_r <= prod_r[G+S-1:G];   // floor(left * gain / 2^G)
    end
    if (state_r == ST_DONE && out_free) begin
      out_left_r  <= lim_l_r;
      out_right_r <= prod_r[G+S-1:G];
      out_gain_r  <= held_r;
      out_red_r   <= (held_r < UNITY);
      out_blk_r   <= eob_r & any_red_r;
      out_last_r  <= eob_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_blk_r, out_red_r, out_gain_r, out_right_r, out_left_r});

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= UNITY)
    else $error("held gain above unity");

  a_blk_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> !out_blk_r)
    else $error("block_reduced set on a non-final beat");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy || div_stat.done |-> state_r == ST_DIV)
    else $error("divider active outside divide step");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_PEAK)
    else $error("accepted beat did not start the sequence");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && state_nxt == ST_IDLE |=> out_valid_r)
    else $error("finished frame not presented");

endmodule

// ===== rtl/lpl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_div: iterative restoring divider for the required gain
// One quotient bit per cycle. The caller guarantees the high dividend part
// is below the divisor, so the quotient fits in GAIN_FRAC_BITS bits.
// ----------------------------------------------------------------------------
module lpl_div import lpl_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SAMPLE_BITS-1:0]    dividend_hi,
  input  logic [GAIN_FRAC_BITS-1:0] dividend_lo,
  input  logic [SAMPLE_BITS-1:0]    divisor,
  output logic [GAIN_FRAC_BITS-1:0] quotient,
  output lpl_div_stat_t             stat
);

  localparam int S  = SAMPLE_BITS;
  localparam int G  = GAIN_FRAC_BITS;
  localparam int CW = $clog2(G + 1);

  logic [S-1:0]  rem_r, rem_nxt;
  logic [G-1:0]  lo_r, lo_nxt;
  logic [G-1:0]  q_r, q_nxt;
  logic [S-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [S:0] rem_sh;
  logic [S:0] diff;
  logic       ge;

  always_comb begin
    rem_sh  = {rem_r, lo_r[G-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[S-1:0] : rem_sh[S-1:0];
    q_nxt   = {q_r[G-2:0], ge};
    lo_nxt  = {lo_r[G-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle as the last quotient bit is registered
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(G);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend_hi;
      lo_r  <= dividend_lo;
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
